// ===== design/epsp_pkg.sv =====
// shared types and constants of the elastic page slot pool
package epsp_pkg;

   // request kinds carried in the req_type field
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_MEMORY  = 2'd1,
      STATUS_INVALID    = 2'd2
   } status_code_type;

   localparam int unsigned START_WIDTH   = 9;
   localparam int unsigned START_RESET   = 64;
   localparam int unsigned GROW_MIN      = 8;
   localparam int unsigned LOW_MIN       = 4;

   // request word
   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   slot_index;
   } req_word_type;

   // result word
   typedef struct packed {
      status_code_type status;
      logic [7:0]      granted_slot;
      logic [8:0]      pages_now;
      logic [8:0]      free_now;
   } rsp_word_type;

   // controller states
   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DISPATCH,
      ST_GROW,
      ST_GROW_END,
      ST_POP,
      ST_POP_TAKE,
      ST_SHRINK_CHECK,
      ST_SHRINK_LOOP,
      ST_SCAN,
      ST_MOVE,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic            init;
      logic            sweep_clr;
      logic            sweep_step;
      logic            latch;
      logic            set_status;
      status_code_type status_code;
      logic            grow_setup;
      logic            grow_push;
      logic            grow_finish;
      logic            pop;
      logic            take;
      logic            free_push;
      logic            shrink_setup;
      logic            scan_start;
      logic            scan_next;
      logic            remove;
      logic            move;
      logic            load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_free;
      logic slot_bad;
      logic ft_zero;
      logic pool_full;
      logic grow_last;
      logic low_hit;
      logic shrink_go;
      logic shrink_more;
      logic scan_match;
      logic scan_end;
      logic sweep_last;
      logic rsp_space;
   } stat_type;

endpackage

// ===== design/epsp_ram.sv =====
// generic single-port-write, registered-read ram
module epsp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/epsp_datapath.sv =====
// datapath of the slot pool: counters, free stack memory and result register
module epsp_datapath #(
   parameter int unsigned POOL_SLOTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  epsp_pkg::cmd_type      cmd,
   output epsp_pkg::stat_type     stat,
   input  epsp_pkg::req_word_type req_data,
   input  logic [8:0]             csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output epsp_pkg::rsp_word_type rsp_data
);

   localparam int unsigned CW   = $clog2(POOL_SLOTS + 1);
   localparam int unsigned AW   = $clog2(POOL_SLOTS);
   localparam int unsigned CMPW = (CW > 9) ? CW : 9;
   localparam int unsigned W2   = CW + 2;

   // clamp a start value to the pool size
   function automatic logic [CW-1:0] clamp_start(input logic [8:0] v);
      if (CMPW'(v) > CMPW'(POOL_SLOTS)) begin
         return CW'(POOL_SLOTS);
      end
      return CW'(v);
   endfunction

   // low mark: max(total/8, 4), kept below the total
   function automatic logic [CW-1:0] calc_low(input logic [CW-1:0] total);
      logic [CW-1:0] low;
      if (total == '0) begin
         return '0;
      end
      low = total >> 3;
      if (low < CW'(epsp_pkg::LOW_MIN)) begin
         low = CW'(epsp_pkg::LOW_MIN);
      end
      if (low >= total) begin
         low = total - 1'b1;
      end
      return low;
   endfunction

   localparam logic [CW-1:0] RESET_COUNT = clamp_start(9'(epsp_pkg::START_RESET));

   logic [CW-1:0]              ft_ff, ft_in;
   logic [CW-1:0]              pp_ff, pp_in;
   logic [CW-1:0]              low_ff, low_in;
   logic [CW-1:0]              floor_ff, floor_in;
   logic [CW-1:0]              by_ff, by_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic [CW-1:0]              target_ff, target_in;
   logic [AW-1:0]              sw_ff, sw_in;
   epsp_pkg::req_word_type     req_ff, req_in;
   epsp_pkg::status_code_type  status_ff, status_in;
   logic [AW-1:0]              granted_ff, granted_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   epsp_pkg::rsp_word_type     rsp_data_ff, rsp_data_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              rd_data;

   logic [CW-1:0]              half;
   logic [CW-1:0]              grow_by;
   logic [CW-1:0]              room;
   logic [W2-1:0]              tri_pp;
   logic [W2-1:0]              quad_ft;
   logic [CW-1:0]              target0;

   // free stack
   epsp_ram #(
      .WIDTH (AW),
      .DEPTH (POOL_SLOTS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // grow amount and shrink thresholds
   always_comb begin
      half    = pp_ff >> 1;
      grow_by = (half < CW'(epsp_pkg::GROW_MIN)) ? CW'(epsp_pkg::GROW_MIN) : half;
      room    = CW'(POOL_SLOTS) - pp_ff;
      if (grow_by > room) begin
         grow_by = room;
      end
      tri_pp  = (W2'(pp_ff) << 1) + W2'(pp_ff);
      quad_ft = W2'(ft_ff) << 2;
      target0 = CW'(tri_pp >> 2);
   end

   // status to controller
   always_comb begin
      stat.is_free     = (req_ff.req_type == epsp_pkg::REQ_FREE);
      stat.slot_bad    = (CMPW'(req_ff.slot_index) >= CMPW'(pp_ff));
      stat.ft_zero     = (ft_ff == '0);
      stat.pool_full   = (pp_ff >= CW'(POOL_SLOTS));
      stat.grow_last   = (k_ff == by_ff - 1'b1);
      stat.low_hit     = (ft_ff <= low_ff);
      stat.shrink_go   = (pp_ff > floor_ff) && (quad_ft >= tri_pp);
      stat.shrink_more = (pp_ff > target_ff);
      stat.scan_match  = (CW'(rd_data) == pp_ff - 1'b1);
      stat.scan_end    = (CW'(pos_ff) + 1'b1 == ft_ff);
      stat.sweep_last  = (sw_ff == AW'(POOL_SLOTS - 1));
      stat.rsp_space   = !rsp_valid_ff || !rsp_stall;
   end

   // next state of counters and memory access
   always_comb begin
      ft_in        = ft_ff;
      pp_in        = pp_ff;
      floor_in     = floor_ff;
      by_in        = by_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      target_in    = target_ff;
      sw_in        = sw_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // reinitialize from a new start value
      if (cmd.init) begin
         ft_in    = clamp_start(csr_data);
         pp_in    = clamp_start(csr_data);
         floor_in = clamp_start(csr_data);
      end

      // refill pass: entry i holds i
      if (cmd.sweep_clr) begin
         sw_in = '0;
      end
      if (cmd.sweep_step) begin
         wr_en   = 1'b1;
         wr_addr = sw_ff;
         wr_data = sw_ff;
         sw_in   = sw_ff + 1'b1;
      end

      // capture a new request
      if (cmd.latch) begin
         req_in     = req_data;
         status_in  = epsp_pkg::STATUS_OK;
         granted_in = '0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end

      // grow: push fresh slots one per cycle
      if (cmd.grow_setup) begin
         by_in = grow_by;
         k_in  = '0;
      end
      if (cmd.grow_push) begin
         if (ft_ff < CW'(POOL_SLOTS)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(ft_ff);
            wr_data = AW'(pp_ff + k_ff);
            ft_in   = ft_ff + 1'b1;
         end
         k_in = k_ff + 1'b1;
      end
      if (cmd.grow_finish) begin
         pp_in = pp_ff + by_ff;
      end

      // pop the top of the stack
      if (cmd.pop) begin
         ft_in   = ft_ff - 1'b1;
         rd_en   = 1'b1;
         rd_addr = AW'(ft_ff - 1'b1);
      end
      if (cmd.take) begin
         granted_in = rd_data;
      end

      // push a returned slot
      if (cmd.free_push) begin
         if ((ft_ff < pp_ff) && (ft_ff < CW'(POOL_SLOTS))) begin
            wr_en   = 1'b1;
            wr_addr = AW'(ft_ff);
            wr_data = AW'(req_ff.slot_index);
            ft_in   = ft_ff + 1'b1;
         end
      end

      // shrink: scan for the top slot, then fill its hole with the top entry
      if (cmd.shrink_setup) begin
         target_in = (target0 < floor_ff) ? floor_ff : target0;
         pos_in    = '0;
      end
      if (cmd.scan_start) begin
         rd_en   = 1'b1;
         rd_addr = pos_ff;
      end
      if (cmd.scan_next) begin
         pos_in  = pos_ff + 1'b1;
         rd_en   = 1'b1;
         rd_addr = pos_ff + 1'b1;
      end
      if (cmd.remove) begin
         ft_in   = ft_ff - 1'b1;
         pp_in   = pp_ff - 1'b1;
         rd_en   = 1'b1;
         rd_addr = AW'(ft_ff - 1'b1);
      end
      if (cmd.move) begin
         if (CW'(pos_ff) != ft_ff) begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data;
         end
         pos_in = '0;
      end

      // result register
      if (cmd.load_rsp) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = status_ff;
         rsp_data_in.granted_slot = 8'(granted_ff);
         rsp_data_in.pages_now    = 9'(pp_ff);
         rsp_data_in.free_now     = 9'(ft_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      low_in = calc_low(pp_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ft_ff        <= RESET_COUNT;
         pp_ff        <= RESET_COUNT;
         floor_ff     <= RESET_COUNT;
         low_ff       <= calc_low(RESET_COUNT);
         sw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ft_ff        <= ft_in;
         pp_ff        <= pp_in;
         floor_ff     <= floor_in;
         low_ff       <= low_in;
         sw_ff        <= sw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      by_ff       <= by_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      target_ff   <= target_in;
      req_ff      <= req_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/epsp_ctrl.sv =====
// controller state machine of the slot pool
module epsp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               csr_valid,
   input  logic               csr_fire,
   input  epsp_pkg::stat_type stat,
   output epsp_pkg::cmd_type  cmd
);

   epsp_pkg::state_type state_ff, state_in;
   logic                after_pop_ff, after_pop_in;
   logic                accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epsp_pkg::ST_SWEEP;
         after_pop_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_pop_ff <= after_pop_in;
      end
   end

   assign req_stall = (state_ff != epsp_pkg::ST_IDLE) || csr_valid;
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      after_pop_in = after_pop_ff;
      cmd          = '0;
      case (state_ff)
         epsp_pkg::ST_SWEEP: begin
            if (!csr_fire) begin
               cmd.sweep_step = 1'b1;
               if (stat.sweep_last) begin
                  state_in = epsp_pkg::ST_IDLE;
               end
            end
         end
         epsp_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               state_in  = epsp_pkg::ST_DISPATCH;
            end
         end
         epsp_pkg::ST_DISPATCH: begin
            if (stat.is_free) begin
               if (stat.slot_bad) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = epsp_pkg::STATUS_INVALID;
                  state_in        = epsp_pkg::ST_DONE;
               end else begin
                  cmd.free_push = 1'b1;
                  state_in      = epsp_pkg::ST_SHRINK_CHECK;
               end
            end else if (stat.ft_zero) begin
               if (stat.pool_full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = epsp_pkg::STATUS_NO_MEMORY;
                  state_in        = epsp_pkg::ST_DONE;
               end else begin
                  cmd.grow_setup = 1'b1;
                  after_pop_in   = 1'b0;
                  state_in       = epsp_pkg::ST_GROW;
               end
            end else begin
               state_in = epsp_pkg::ST_POP;
            end
         end
         epsp_pkg::ST_GROW: begin
            cmd.grow_push = 1'b1;
            if (stat.grow_last) begin
               state_in = epsp_pkg::ST_GROW_END;
            end
         end
         epsp_pkg::ST_GROW_END: begin
            cmd.grow_finish = 1'b1;
            state_in        = after_pop_ff ? epsp_pkg::ST_DONE : epsp_pkg::ST_POP;
         end
         epsp_pkg::ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = epsp_pkg::ST_POP_TAKE;
         end
         epsp_pkg::ST_POP_TAKE: begin
            cmd.take = 1'b1;
            if (stat.low_hit && !stat.pool_full) begin
               cmd.grow_setup = 1'b1;
               after_pop_in   = 1'b1;
               state_in       = epsp_pkg::ST_GROW;
            end else begin
               state_in = epsp_pkg::ST_DONE;
            end
         end
         epsp_pkg::ST_SHRINK_CHECK: begin
            if (stat.shrink_go) begin
               cmd.shrink_setup = 1'b1;
               state_in         = epsp_pkg::ST_SHRINK_LOOP;
            end else begin
               state_in = epsp_pkg::ST_DONE;
            end
         end
         epsp_pkg::ST_SHRINK_LOOP: begin
            if (stat.shrink_more && !stat.ft_zero) begin
               cmd.scan_start = 1'b1;
               state_in       = epsp_pkg::ST_SCAN;
            end else begin
               state_in = epsp_pkg::ST_DONE;
            end
         end
         epsp_pkg::ST_SCAN: begin
            if (stat.scan_match) begin
               cmd.remove = 1'b1;
               state_in   = epsp_pkg::ST_MOVE;
            end else if (stat.scan_end) begin
               state_in = epsp_pkg::ST_DONE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         epsp_pkg::ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = epsp_pkg::ST_SHRINK_LOOP;
         end
         epsp_pkg::ST_DONE: begin
            if (stat.rsp_space) begin
               cmd.load_rsp = 1'b1;
               state_in     = epsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = epsp_pkg::ST_IDLE;
         end
      endcase

      // register write reinitializes the pool and refills the stack
      if (csr_fire) begin
         cmd.init      = 1'b1;
         cmd.sweep_clr = 1'b1;
         cmd.sweep_step = 1'b0;
         state_in      = epsp_pkg::ST_SWEEP;
      end
   end

endmodule

// ===== design/elastic_page_slot_pool.sv =====
// top level of the elastic page slot pool
//
//   port group  direction  handshake          word
//   req_        in         req_valid/stall    req_type, slot_index
//   rsp_        out        rsp_valid/stall    status, granted_slot, pages_now, free_now
//   csr_        in         csr_valid/ready    start_pages
//
// allocate: pops the top of the stack; an empty stack first grows the pool, or
// gets no memory when the pool is full; a pop to or below the low mark grows a
// pool that is not full. free: a bad slot gets invalid; else the slot is pushed
// and a shrink may start, each slot shrunk scanning up to free_now stack reads; a
// scan missing the top slot ends the shrink. after reset and every csr write the
// stack refills with req_stall high; a result held by rsp_stall lets the next word in.
module elastic_page_slot_pool #(
   parameter int unsigned POOL_SLOTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  epsp_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output epsp_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [8:0]             csr_data
);

   epsp_pkg::cmd_type  cmd;
   epsp_pkg::stat_type stat;
   logic               csr_fire;

   // the register is always writable
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // controller
   epsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_fire  (csr_fire),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   epsp_datapath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb_top.sv =====
// testbench for the elastic page slot pool: directed table, random traffic, shadow pool check
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import epsp_pkg::*;

   localparam int unsigned POOL_SLOTS    = 256;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned CSR_SETTLE    = 8;
   localparam int unsigned END_SETTLE    = 60;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned HOLD_AFTER    = 500;
   localparam int unsigned REPORT_MAX    = 10;
   localparam int unsigned DIRECTED_ROWS = 24;
   localparam int unsigned PHASE_COUNT   = 8;

   // kinds of rows in the directed table
   typedef enum logic {
      ROW_WORD,
      ROW_START
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_kind_type op;
      logic [8:0]   value;
      bit           typed;
      rsp_word_type want;
   } script_row_type;

   typedef struct {
      logic [8:0]  start;
      int unsigned words;
      int unsigned alloc_pct;
      bit          steady;
   } phase_type;

   localparam rsp_word_type ANY_WORD = '0;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [8:0]   csr_data  = '0;

   // shadow copy of the pool
   logic [7:0]   shadow_stack [POOL_SLOTS];
   logic [8:0]   shadow_free;
   logic [8:0]   shadow_pages;
   logic [8:0]   shadow_low;
   logic [8:0]   shadow_floor;

   rsp_word_type owed_results [$];
   logic [7:0]   held_slots [$];
   int unsigned  words_taken = 0;
   int unsigned  mismatches  = 0;
   int unsigned  cycles      = 0;
   bit           sender_steady = 1'b0;

   elastic_page_slot_pool #(
      .POOL_SLOTS (POOL_SLOTS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5ns clock = ~clock;

   // low mark of a pool of the given size
   function automatic logic [8:0] low_mark_of(input logic [8:0] total);
      logic [8:0] mark;
      if (total == 0) return '0;
      mark = total >> 3;
      if (mark < LOW_MIN) mark = 9'(LOW_MIN);
      if (mark >= total) mark = total - 9'd1;
      return mark;
   endfunction

   // fresh pool after reset or a start_pages write
   function automatic void pool_init(input logic [8:0] start);
      logic [8:0] n;
      int         i;
      n = (start > POOL_SLOTS) ? 9'(POOL_SLOTS) : start;
      for (i = 0; i < POOL_SLOTS; i++) shadow_stack[i] = 8'(i);
      shadow_free  = n;
      shadow_pages = n;
      shadow_floor = n;
      shadow_low   = low_mark_of(n);
   endfunction

   // add fresh slots on top of the pool
   function automatic void pool_grow();
      int unsigned by;
      int unsigned k;
      if (shadow_pages >= POOL_SLOTS) return;
      by = shadow_pages / 2;
      if (by < GROW_MIN) by = GROW_MIN;
      if (by > POOL_SLOTS - shadow_pages) by = POOL_SLOTS - shadow_pages;
      for (k = 0; k < by; k++) begin
         if (shadow_free < POOL_SLOTS) begin
            shadow_stack[shadow_free] = 8'(shadow_pages + k);
            shadow_free++;
         end
      end
      shadow_pages = shadow_pages + 9'(by);
      shadow_low   = low_mark_of(shadow_pages);
   endfunction

   // one request word against the shadow pool
   function automatic rsp_word_type pool_step(input req_word_type w);
      rsp_word_type r;
      int unsigned  target;
      int unsigned  pos;
      bit           found;
      logic [8:0]   top;
      r = ANY_WORD;
      r.status = STATUS_OK;
      if (w.req_type == REQ_ALLOC) begin
         if (shadow_free == 0) pool_grow();
         if (shadow_free == 0) begin
            r.status = STATUS_NO_MEMORY;
         end else begin
            shadow_free--;
            r.granted_slot = shadow_stack[shadow_free];
            if (shadow_free <= shadow_low) pool_grow();
         end
      end else if (w.slot_index >= shadow_pages) begin
         r.status = STATUS_INVALID;
      end else begin
         // push unless the stack already covers the whole pool
         if (shadow_free < shadow_pages && shadow_free < POOL_SLOTS) begin
            shadow_stack[shadow_free] = w.slot_index;
            shadow_free++;
         end
         // shrink from the top while the top slot is free
         if (shadow_pages > shadow_floor && 4 * shadow_free >= 3 * shadow_pages) begin
            target = (shadow_pages * 3) / 4;
            if (target < shadow_floor) target = shadow_floor;
            while (shadow_pages > target) begin
               top   = shadow_pages - 9'd1;
               found = 1'b0;
               for (pos = 0; pos < shadow_free; pos++) begin
                  if (shadow_stack[pos] == top) begin
                     found = 1'b1;
                     break;
                  end
               end
               if (!found) break;
               shadow_free--;
               shadow_stack[pos] = shadow_stack[shadow_free];
               shadow_pages--;
            end
            shadow_low = low_mark_of(shadow_pages);
         end
      end
      r.pages_now = shadow_pages;
      r.free_now  = shadow_free;
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one request word and record what it must return
   task automatic offer_word(input req_word_type w, input bit typed, input rsp_word_type want);
      int unsigned  gap;
      rsp_word_type predicted;
      gap = sender_steady ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predicted = pool_step(w);
      owed_results.push_back(typed ? want : predicted);
      words_taken++;
      if (w.req_type == REQ_ALLOC && predicted.status == STATUS_OK)
         held_slots.push_back(predicted.granted_slot);
   endtask

   // stop offering and wait until every owed result has come back
   task automatic settle_idle(input int unsigned extra);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // write start_pages while the pool is quiet
   task automatic write_start(input logic [8:0] value);
      settle_idle(CSR_SETTLE);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_init(value);
      held_slots.delete();
   endtask

   // stimulus
   initial begin
      script_row_type rows [DIRECTED_ROWS];
      phase_type      phases [PHASE_COUNT];
      req_word_type   w;
      int unsigned    pick;
      int unsigned    n;

      rows = '{
         '{ROW_WORD,  REQ_ALLOC, 9'd0,   1'b1, '{STATUS_OK,      8'd63,  9'd64,  9'd63}},
         '{ROW_WORD,  REQ_FREE,  9'd255, 1'b1, '{STATUS_INVALID, 8'd0,   9'd64,  9'd63}},
         '{ROW_WORD,  REQ_FREE,  9'd64,  1'b1, '{STATUS_INVALID, 8'd0,   9'd64,  9'd63}},
         '{ROW_WORD,  REQ_FREE,  9'd63,  1'b1, '{STATUS_OK,      8'd0,   9'd64,  9'd64}},
         '{ROW_WORD,  REQ_FREE,  9'd0,   1'b1, '{STATUS_OK,      8'd0,   9'd64,  9'd64}},
         '{ROW_WORD,  REQ_ALLOC, 9'd255, 1'b1, '{STATUS_OK,      8'd63,  9'd64,  9'd63}},
         '{ROW_WORD,  REQ_FREE,  9'd63,  1'b0, ANY_WORD},
         '{ROW_START, REQ_ALLOC, 9'd1,   1'b0, ANY_WORD},
         '{ROW_WORD,  REQ_ALLOC, 9'd0,   1'b1, '{STATUS_OK,      8'd0,   9'd9,   9'd8}},
         '{ROW_WORD,  REQ_ALLOC, 9'd0,   1'b0, ANY_WORD},
         '{ROW_WORD,  REQ_FREE,  9'd8,   1'b0, ANY_WORD},
         '{ROW_WORD,  REQ_FREE,  9'd9,   1'b0, ANY_WORD},
         '{ROW_START, REQ_ALLOC, 9'd0,   1'b0, ANY_WORD},
         '{ROW_WORD,  REQ_ALLOC, 9'd0,   1'b1, '{STATUS_OK,      8'd7,   9'd8,   9'd7}},
         '{ROW_WORD,  REQ_FREE,  9'd128, 1'b1, '{STATUS_INVALID, 8'd0,   9'd8,   9'd7}},
         '{ROW_WORD,  REQ_FREE,  9'd7,   1'b0, ANY_WORD},
         '{ROW_START, REQ_ALLOC, 9'd511, 1'b0, ANY_WORD},
         '{ROW_WORD,  REQ_ALLOC, 9'd0,   1'b1, '{STATUS_OK,      8'd255, 9'd256, 9'd255}},
         '{ROW_WORD,  REQ_FREE,  9'd255, 1'b1, '{STATUS_OK,      8'd0,   9'd256, 9'd256}},
         '{ROW_WORD,  REQ_FREE,  9'd170, 1'b1, '{STATUS_OK,      8'd0,   9'd256, 9'd256}},
         '{ROW_WORD,  REQ_ALLOC, 9'd85,  1'b0, ANY_WORD},
         '{ROW_START, REQ_ALLOC, 9'd300, 1'b0, ANY_WORD},
         '{ROW_WORD,  REQ_ALLOC, 9'd0,   1'b0, ANY_WORD},
         '{ROW_START, REQ_ALLOC, 9'd64,  1'b0, ANY_WORD}
      };

      // start size, words, share of allocates, sender without gaps
      phases = '{
         '{9'd1,                       200, 60, 1'b0},
         '{9'd511,                     320, 95, 1'b0},
         '{9'd0,                       150, 50, 1'b1},
         '{9'd256,                     180, 40, 1'b0},
         '{9'd8,                       200, 70, 1'b0},
         '{9'($urandom_range(2, 255)), 200, 55, 1'b0},
         '{9'($urandom_range(0, 511)), 200, 65, 1'b0},
         '{9'd64,                      150, 50, 1'b0}
      };

      pool_init(9'(START_RESET));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_START) begin
            write_start(rows[i].value);
         end else begin
            w.req_type   = rows[i].op;
            w.slot_index = rows[i].value[7:0];
            offer_word(w, rows[i].typed, rows[i].want);
         end
      end

      // random phases, frees mostly return slots that are held
      foreach (phases[p]) begin
         write_start(phases[p].start);
         sender_steady = phases[p].steady;
         for (n = 0; n < phases[p].words; n++) begin
            if ($urandom_range(0, 99) < phases[p].alloc_pct) begin
               w.req_type   = REQ_ALLOC;
               w.slot_index = 8'($urandom_range(0, 255));
            end else begin
               w.req_type = REQ_FREE;
               if (held_slots.size() != 0 && $urandom_range(0, 99) < 80) begin
                  pick         = $urandom_range(0, held_slots.size() - 1);
                  w.slot_index = held_slots[pick];
                  held_slots.delete(pick);
               end else begin
                  w.slot_index = 8'($urandom_range(0, 255));
               end
            end
            offer_word(w, 1'b0, ANY_WORD);
         end
      end

      settle_idle(END_SETTLE);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // result side stalls, with one long hold-off while the sender keeps going
   initial begin : result_sink
      int unsigned stall_len;
      int unsigned run_len;
      bit          hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && words_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall_len = idle_len();
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12);
            if (stall_len != 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   // compare each result word with the oldest owed one
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result word: status %0d slot %0d pages %0d free %0d",
                        rsp_data.status, rsp_data.granted_slot, rsp_data.pages_now,
                        rsp_data.free_now);
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.granted_slot !== want.granted_slot
                || rsp_data.pages_now !== want.pages_now
                || rsp_data.free_now !== want.free_now) begin
               mismatches++;
               // fields in order: status, slot, pages, free
               if (mismatches <= REPORT_MAX)
                  $display("result mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           want.status, want.granted_slot, want.pages_now, want.free_now,
                           rsp_data.status, rsp_data.granted_slot, rsp_data.pages_now,
                           rsp_data.free_now);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
design/epsp_pkg.sv
design/epsp_ram.sv
design/epsp_datapath.sv
design/epsp_ctrl.sv
design/elastic_page_slot_pool.sv
verif/tb_top.sv
